[rtl/sau_pkg.sv]
package sau_pkg;

  // Request word
  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] push_value;
  } req_word_t;

  // Response word
  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] top_value;
    logic [6:0]         stack_depth;
  } rsp_word_t;

  // Operation codes carried in req_type
  localparam logic [2:0] OP_PUSH = 3'd0;
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_SUB  = 3'd2;
  localparam logic [2:0] OP_MUL  = 3'd3;
  localparam logic [2:0] OP_DIV  = 3'd4;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_SHORT   = 2'd1;
  localparam logic [1:0] ST_DIVZERO = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  // Fewest operands an arithmetic operation needs
  localparam int MIN_OPERANDS = 2;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV
  } alu_op_t;

  // Command from the sequencer to the arithmetic unit
  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef enum logic [2:0] {
    A_IDLE,
    A_ADDSUB,
    A_ABS_L,
    A_ABS_R,
    A_MUL,
    A_DIV,
    A_FIX,
    A_DONE
  } alu_state_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WAIT,
    S_RESP
  } seq_state_t;

endpackage

[rtl/stack_arithmetic_unit_core.sv]
// Operand stack of signed words with push, add, sub, mul and div.
// Request channel (req, req_valid, req_stall): one word per operation,
// req_type selects the operation and push_value is the pushed operand.
// Response channel (rsp, rsp_valid, rsp_stall): exactly one word per
// request with status, the new top of stack (zero when empty) and depth.
// One request is in flight at a time; req_stall is high from acceptance
// until the response is loaded into the output register.
// Push, errors and unknown codes go from acceptance straight to the
// response state; add/sub, mul and div first pass through S_EXEC and
// S_WAIT while the arithmetic unit runs. Mul and div take longest, as
// the shared adder retires one bit per cycle for them.
// The top of stack lives in a register, the rest in a single-port-write,
// registered-read RAM; an arithmetic op reads the second entry in the
// cycle after acceptance.
// A stalled response holds in the output register; the next request is
// taken meanwhile, and its own response waits until that one is taken.
// Reset empties the stack and drops any pending response; no clearing
// pass is needed.
module stack_arithmetic_unit_core #(
  parameter int STACK_DEPTH = 64,
  parameter int WORD_WIDTH  = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  sau_pkg::req_word_t req,
  input  logic               req_valid,
  output logic               req_stall,
  output sau_pkg::rsp_word_t rsp,
  output logic               rsp_valid,
  input  logic               rsp_stall
);

  import sau_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int DW = $clog2(STACK_DEPTH + 1);

  seq_state_t            state, state_next;
  logic [DW-1:0]         depth, depth_next;
  logic [WORD_WIDTH-1:0] top, top_next;
  logic [1:0]            status, status_next;
  alu_op_t               op_q, op_q_next;
  rsp_word_t             rsp_next;
  logic                  rsp_valid_next;

  logic                  wr_en, rd_en;
  logic [AW-1:0]         wr_addr, rd_addr;
  logic [WORD_WIDTH-1:0] rd_data;

  alu_req_t              alu_ctl;
  logic                  alu_done;
  logic [WORD_WIDTH-1:0] alu_result;

  logic                  accept;
  logic [DW-1:0]         depth_m1, depth_m2;
  logic [WORD_WIDTH+31:0] push_ext;
  logic [WORD_WIDTH-1:0] push_word;
  logic [WORD_WIDTH+31:0] top_ext;
  logic [DW+6:0]         depth_ext;

  assign accept    = req_valid & ~req_stall;
  assign req_stall = (state != S_IDLE);

  assign depth_m1  = depth - DW'(1);
  assign depth_m2  = depth - DW'(MIN_OPERANDS);

  // Push operand sign-extended or truncated to the stack word
  assign push_ext  = {{WORD_WIDTH{req.push_value[31]}}, req.push_value};
  assign push_word = push_ext[WORD_WIDTH-1:0];

  // Response fields zero-extended or truncated to their port widths
  assign top_ext   = {32'b0, (depth != '0) ? top : '0};
  assign depth_ext = {7'b0, depth_next};

  sau_ram #(
    .WIDTH (WORD_WIDTH),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (top),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sau_alu #(
    .WIDTH (WORD_WIDTH)
  ) u_alu (
    .clk    (clk),
    .rst    (rst),
    .ctl    (alu_ctl),
    .lhs    (rd_data),
    .rhs    (top),
    .done   (alu_done),
    .result (alu_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      depth     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      depth     <= depth_next;
      rsp_valid <= rsp_valid_next;
    end
    top    <= top_next;
    status <= status_next;
    op_q   <= op_q_next;
    rsp    <= rsp_next;
  end

  // Operation sequencer
  always_comb begin
    state_next     = state;
    depth_next     = depth;
    top_next       = top;
    status_next    = status;
    op_q_next      = op_q;
    rsp_next       = rsp;
    rsp_valid_next = rsp_valid & rsp_stall;
    wr_en          = 1'b0;
    wr_addr        = depth_m1[AW-1:0];
    rd_en          = 1'b0;
    rd_addr        = depth_m2[AW-1:0];
    alu_ctl.start  = 1'b0;
    alu_ctl.op     = op_q;
    case (state)
      S_IDLE: begin
        if (accept) begin
          status_next = ST_OK;
          state_next  = S_RESP;
          case (req.req_type)
            OP_PUSH: begin
              if (depth == DW'(STACK_DEPTH)) begin
                status_next = ST_FULL;
              end else begin
                // old top spills into the RAM
                wr_en      = (depth != '0);
                top_next   = push_word;
                depth_next = depth + DW'(1);
              end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
              if (depth < DW'(MIN_OPERANDS)) begin
                status_next = ST_SHORT;
              end else if (req.req_type == OP_DIV && top == '0) begin
                status_next = ST_DIVZERO;
              end else begin
                rd_en      = 1'b1;
                state_next = S_EXEC;
                case (req.req_type)
                  OP_ADD:  op_q_next = ALU_ADD;
                  OP_SUB:  op_q_next = ALU_SUB;
                  OP_MUL:  op_q_next = ALU_MUL;
                  default: op_q_next = ALU_DIV;
                endcase
              end
            end
            default: begin
              // unknown code: stack untouched, status ok
            end
          endcase
        end
      end
      S_EXEC: begin
        alu_ctl.start = 1'b1;
        state_next    = S_WAIT;
      end
      S_WAIT: begin
        if (alu_done) begin
          top_next   = alu_result;
          depth_next = depth_m1;
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_next.status      = status;
          rsp_next.top_value   = top_ext[31:0];
          rsp_next.stack_depth = depth_ext[6:0];
          rsp_valid_next       = 1'b1;
          state_next           = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[rtl/sau_ram.sv]
module sau_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/sau_alu.sv]
module sau_alu #(
  parameter int WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  sau_pkg::alu_req_t ctl,
  input  logic [WIDTH-1:0]  lhs,
  input  logic [WIDTH-1:0]  rhs,
  output logic              done,
  output logic [WIDTH-1:0]  result
);

  import sau_pkg::*;

  localparam int CW = $clog2(WIDTH);

  alu_state_t       state, state_next;
  alu_op_t          op_q, op_q_next;
  logic [WIDTH-1:0] acc, acc_next;     // product, remainder, result
  logic [WIDTH-1:0] opd, opd_next;     // multiplicand or divisor
  logic [WIDTH-1:0] shf, shf_next;     // multiplier or dividend, then quotient
  logic [CW-1:0]    cnt, cnt_next;
  logic             neg, neg_next;

  // The one shared adder/subtractor, two bits wider to give a borrow
  logic [WIDTH+1:0] add_x, add_y, sum;
  logic             add_sub;
  logic             ge;

  assign sum = add_x + (add_sub ? ~add_y : add_y) + {{(WIDTH+1){1'b0}}, add_sub};
  assign ge  = ~sum[WIDTH+1];

  assign result = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
    end else begin
      state <= state_next;
    end
    op_q <= op_q_next;
    acc  <= acc_next;
    opd  <= opd_next;
    shf  <= shf_next;
    cnt  <= cnt_next;
    neg  <= neg_next;
  end

  // Sequencer around the shared adder
  always_comb begin
    state_next = state;
    op_q_next  = op_q;
    acc_next   = acc;
    opd_next   = opd;
    shf_next   = shf;
    cnt_next   = cnt;
    neg_next   = neg;
    add_x      = '0;
    add_y      = '0;
    add_sub    = 1'b0;
    done       = 1'b0;
    case (state)
      A_IDLE: begin
        if (ctl.start) begin
          op_q_next = ctl.op;
          acc_next  = '0;
          shf_next  = lhs;
          opd_next  = rhs;
          cnt_next  = '0;
          neg_next  = lhs[WIDTH-1] ^ rhs[WIDTH-1];
          case (ctl.op)
            ALU_ADD, ALU_SUB: state_next = A_ADDSUB;
            ALU_MUL:          state_next = A_MUL;
            ALU_DIV:          state_next = A_ABS_L;
            default:          state_next = A_ADDSUB;
          endcase
        end
      end
      A_ADDSUB: begin
        add_x      = {2'b00, shf};
        add_y      = {2'b00, opd};
        add_sub    = (op_q == ALU_SUB);
        acc_next   = sum[WIDTH-1:0];
        state_next = A_DONE;
      end
      // Dividend magnitude
      A_ABS_L: begin
        add_y   = {2'b00, shf};
        add_sub = 1'b1;
        if (shf[WIDTH-1]) begin
          shf_next = sum[WIDTH-1:0];
        end
        state_next = A_ABS_R;
      end
      // Divisor magnitude
      A_ABS_R: begin
        add_y   = {2'b00, opd};
        add_sub = 1'b1;
        if (opd[WIDTH-1]) begin
          opd_next = sum[WIDTH-1:0];
        end
        state_next = A_DIV;
      end
      // Shift-add, multiplier MSB first; only the low word is kept
      A_MUL: begin
        add_x    = {1'b0, acc, 1'b0};
        add_y    = shf[WIDTH-1] ? {2'b00, opd} : '0;
        acc_next = sum[WIDTH-1:0];
        shf_next = {shf[WIDTH-2:0], 1'b0};
        cnt_next = cnt + CW'(1);
        if (cnt == CW'(WIDTH - 1)) begin
          state_next = A_DONE;
        end
      end
      // Restoring division, one quotient bit a cycle
      A_DIV: begin
        add_x    = {1'b0, acc, shf[WIDTH-1]};
        add_y    = {2'b00, opd};
        add_sub  = 1'b1;
        acc_next = ge ? sum[WIDTH-1:0] : add_x[WIDTH-1:0];
        shf_next = {shf[WIDTH-2:0], ge};
        cnt_next = cnt + CW'(1);
        if (cnt == CW'(WIDTH - 1)) begin
          state_next = A_FIX;
        end
      end
      // Quotient sign
      A_FIX: begin
        add_y      = {2'b00, shf};
        add_sub    = 1'b1;
        acc_next   = neg ? sum[WIDTH-1:0] : shf;
        state_next = A_DONE;
      end
      A_DONE: begin
        done       = 1'b1;
        state_next = A_IDLE;
      end
      default: begin
        state_next = A_IDLE;
      end
    endcase
  end

endmodule

[tb/sv/stack_arithmetic_unit_core_tb.sv]
module stack_arithmetic_unit_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sau_pkg::*;

  localparam int STACK_LIMIT  = 64;
  localparam int ITEM_TARGET  = 1600;
  localparam int IDLE_LIMIT   = 5000;
  localparam int TAIL_CYCLES  = 60;
  localparam int HOLD_CYCLES  = 300;
  localparam int PRINT_LIMIT  = 40;

  // req_type codes the block treats as no-ops
  localparam logic [2:0] OP_RSVD_A = 3'd5;
  localparam logic [2:0] OP_RSVD_B = 3'd6;
  localparam logic [2:0] OP_RSVD_C = 3'd7;

  localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;

  typedef struct {
    req_word_t word;
    bit        drain_first;
  } queued_op_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  req_word_t req = '0;
  logic      req_valid = 1'b0;
  logic      req_stall;
  rsp_word_t rsp;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;

  stack_arithmetic_unit_core uut (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall)
  );

  always #2 clk = ~clk;

  // Word queues and counters
  queued_op_t ops_to_send[$];
  rsp_word_t  reports_due[$];
  int         words_in = 0;
  int         words_out = 0;
  int         mismatches = 0;
  int         op_seen[8];
  int         status_seen[4];
  int         deepest = 0;

  // Generator bookkeeping (depth estimate never exceeds the real depth)
  int         gen_depth = 0;
  int         real_items = 0;
  bit         hold_for_drain = 1'b0;

  // Shadow operand stack
  logic signed [31:0] shadow_stack[STACK_LIMIT];
  int                 shadow_depth = 0;

  // Apply one operation to the shadow stack and return the expected word
  function automatic rsp_word_t run_stack_op(req_word_t w);
    rsp_word_t          r;
    logic signed [31:0] lhs;
    logic signed [31:0] rhs;
    logic signed [31:0] res;
    longint             wide;
    r = '0;
    r.status = ST_OK;
    case (w.req_type)
      OP_PUSH: begin
        if (shadow_depth >= STACK_LIMIT) begin
          r.status = ST_FULL;
        end else begin
          shadow_stack[shadow_depth] = w.push_value;
          shadow_depth++;
        end
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
        if (shadow_depth < MIN_OPERANDS) begin
          r.status = ST_SHORT;
        end else begin
          lhs = shadow_stack[shadow_depth-2];
          rhs = shadow_stack[shadow_depth-1];
          if (w.req_type == OP_DIV && rhs == 0) begin
            r.status = ST_DIVZERO;
          end else begin
            case (w.req_type)
              OP_ADD: res = lhs + rhs;
              OP_SUB: res = lhs - rhs;
              OP_MUL: res = lhs * rhs;
              default: begin
                // 64-bit quotient so min / -1 wraps instead of overflowing
                wide = longint'(lhs) / longint'(rhs);
                res = wide[31:0];
              end
            endcase
            shadow_stack[shadow_depth-2] = res;
            shadow_depth--;
          end
        end
      end
      default: ;
    endcase
    r.top_value = (shadow_depth != 0) ? shadow_stack[shadow_depth-1] : '0;
    r.stack_depth = 7'(shadow_depth);
    return r;
  endfunction

  task automatic flag_mismatch(string msg);
    if (mismatches < PRINT_LIMIT)
      $display("%0t ns: mismatch at response %0d: %s", $realtime, words_out, msg);
    mismatches++;
  endtask

  // Compare one response word against the oldest prediction
  task automatic check_report(rsp_word_t got);
    rsp_word_t want;
    status_seen[got.status]++;
    if (got.stack_depth > deepest) deepest = got.stack_depth;
    if (reports_due.size() == 0) begin
      flag_mismatch("response word with nothing outstanding");
      return;
    end
    want = reports_due.pop_front();
    if (got.status !== want.status)
      flag_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
    if (got.top_value !== want.top_value)
      flag_mismatch($sformatf("top_value %0d, expected %0d", got.top_value, want.top_value));
    if (got.stack_depth !== want.stack_depth)
      flag_mismatch($sformatf("stack_depth %0d, expected %0d",
                              got.stack_depth, want.stack_depth));
  endtask

  // Mostly short gaps, some medium, a few long
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // Operands biased toward the corners and small values
  function automatic logic signed [31:0] pick_operand();
    case ($urandom_range(0, 15))
      0, 1: return '0;
      2: return -1;
      3: return WORD_MIN;
      4: return WORD_MAX;
      5, 6, 7, 8: return int'($urandom_range(0, 40)) - 20;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] pick_arith();
    case ($urandom_range(0, 3))
      0: return OP_ADD;
      1: return OP_SUB;
      2: return OP_MUL;
      default: return OP_DIV;
    endcase
  endfunction

  task automatic queue_word(logic [2:0] op, logic signed [31:0] val);
    queued_op_t q;
    q.word.req_type = op;
    q.word.push_value = val;
    q.drain_first = hold_for_drain;
    hold_for_drain = 1'b0;
    ops_to_send.push_back(q);
    if (op == OP_PUSH) begin
      if (gen_depth < STACK_LIMIT) gen_depth++;
      real_items++;
    end else if (op <= OP_DIV) begin
      if (gen_depth >= MIN_OPERANDS) gen_depth--;
      real_items++;
    end
  endtask

  // Push up to a full stack, then push against it
  task automatic climb_to_full();
    while (gen_depth < STACK_LIMIT) queue_word(OP_PUSH, pick_operand());
    repeat ($urandom_range(1, 3)) queue_word(OP_PUSH, pick_operand());
  endtask

  task automatic unwind();
    while (gen_depth >= MIN_OPERANDS) queue_word(pick_arith(), pick_operand());
  endtask

  // Sender
  int send_gap = 0;
  int send_calm = 0;

  always @(posedge clk) begin : sender
    bit took;
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      took = req_valid && !req_stall;
      if (took) begin
        reports_due.push_back(run_stack_op(req));
        op_seen[req.req_type]++;
        words_in <= words_in + 1;
        ops_to_send.delete(0);
        if (send_calm > 0) begin
          send_calm--;
          send_gap = 0;
        end else begin
          send_gap = pick_gap();
          if ($urandom_range(0, 49) == 0) send_calm = $urandom_range(20, 80);
        end
      end
      if (req_valid && !took) begin
        // stalled word holds
      end else if (send_gap > 0) begin
        send_gap--;
        req_valid <= 1'b0;
      end else if (ops_to_send.size() > 0 &&
                   (!ops_to_send[0].drain_first || words_in + took == words_out)) begin
        req_valid <= 1'b1;
        req <= ops_to_send[0].word;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Receiver
  int stall_left = 0;
  int recv_calm = 0;
  int hold_left = 0;

  always @(posedge clk) begin : receiver
    bit stall_next;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        check_report(rsp);
        words_out <= words_out + 1;
        if (words_out == 400 || words_out == 1100) hold_left = HOLD_CYCLES;
        if (recv_calm > 0) begin
          recv_calm--;
          stall_left = 0;
        end else begin
          stall_left = pick_gap();
          if ($urandom_range(0, 49) == 0) recv_calm = $urandom_range(20, 80);
        end
      end
      stall_next = 1'b0;
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        stall_next = 1'b1;
      end
      rsp_stall <= stall_next;
    end
  end

  // Watchdog on cycles with no word moving
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t ns: no word moved for %0d cycles", $realtime, IDLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    int kind;
    int target;

    // Directed: short stack, wraps, min / -1, zero divisor, truncation, no-ops
    queue_word(OP_ADD, WORD_MAX);
    queue_word(OP_PUSH, WORD_MAX);
    queue_word(OP_DIV, '0);
    queue_word(OP_PUSH, 1);
    queue_word(OP_ADD, '0);
    queue_word(OP_PUSH, -1);
    queue_word(OP_DIV, '0);
    queue_word(OP_PUSH, '0);
    queue_word(OP_DIV, '0);
    queue_word(OP_MUL, -1);
    queue_word(OP_PUSH, -7);
    queue_word(OP_PUSH, 2);
    queue_word(OP_DIV, '0);
    queue_word(OP_PUSH, WORD_MIN);
    queue_word(OP_SUB, '0);
    queue_word(OP_PUSH, 32'sh0001_0000);
    queue_word(OP_PUSH, 32'sh0001_0000);
    queue_word(OP_MUL, '0);
    queue_word(OP_RSVD_A, $urandom);
    queue_word(OP_RSVD_B, $urandom);
    queue_word(OP_RSVD_C, $urandom);
    queue_word(OP_SUB, '0);
    queue_word(OP_SUB, '0);

    // Let everything drain, then fill the stack to the top
    hold_for_drain = 1'b1;
    climb_to_full();
    unwind();

    // Random segments, mostly well-formed push/compute sequences
    while (real_items < ITEM_TARGET) begin
      kind = $urandom_range(0, 9);
      hold_for_drain = ($urandom_range(0, 5) == 0);
      if (kind <= 5) begin
        target = ($urandom_range(0, 3) == 0) ? $urandom_range(2, STACK_LIMIT)
                                              : $urandom_range(2, 12);
        while (gen_depth < target) begin
          if (gen_depth >= MIN_OPERANDS && $urandom_range(0, 3) == 0)
            queue_word(pick_arith(), pick_operand());
          else
            queue_word(OP_PUSH, pick_operand());
        end
        unwind();
        if ($urandom_range(0, 1) == 0) queue_word(pick_arith(), pick_operand());
      end else if (kind <= 7) begin
        climb_to_full();
        unwind();
      end else if (kind == 8) begin
        repeat ($urandom_range(4, 12)) queue_word(3'($urandom_range(0, 7)), $urandom);
      end else begin
        repeat ($urandom_range(1, 4)) queue_word(pick_arith(), pick_operand());
      end
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (ops_to_send.size() != 0 || reports_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d words: push %0d, add %0d, sub %0d, mul %0d, div %0d, no-op %0d.",
             words_in, op_seen[OP_PUSH], op_seen[OP_ADD], op_seen[OP_SUB],
             op_seen[OP_MUL], op_seen[OP_DIV],
             op_seen[OP_RSVD_A] + op_seen[OP_RSVD_B] + op_seen[OP_RSVD_C]);
    $display("Statuses ok %0d, too short %0d, div by zero %0d, full %0d; deepest %0d.",
             status_seen[ST_OK], status_seen[ST_SHORT], status_seen[ST_DIVZERO],
             status_seen[ST_FULL], deepest);
    if (mismatches == 0 && reports_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
